[rtl/m3inv_pkg.sv]
package m3inv_pkg;

  // element and result word
  localparam int unsigned WORD_W = 32;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned N_EL   = 9;

  // exact widths along the datapath
  localparam int unsigned PROD_W = 64;  // element product, Q32.32
  localparam int unsigned CM_W   = 63;  // cofactor magnitude
  localparam int unsigned TM_W   = 95;  // det term magnitude
  localparam int unsigned DT_W   = 98;  // signed determinant, Q50.48
  localparam int unsigned DM_W   = 97;  // determinant magnitude
  localparam int unsigned QW     = 33;  // quotient bits kept after overflow check
  localparam int unsigned DIV_N  = QW + 1;  // divider register stages

  typedef logic signed [WORD_W-1:0] word_t;

  // cofactor k = a[PA]*a[PB] - a[NA]*a[NB]
  localparam int unsigned CF_PA [N_EL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CF_PB [N_EL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CF_NA [N_EL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CF_NB [N_EL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

[rtl/m3inv_mat_if.sv]
interface m3inv_mat_if;
  import m3inv_pkg::*;

  logic  valid;
  logic  ready;
  word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

[rtl/m3inv_res_if.sv]
interface m3inv_res_if;
  import m3inv_pkg::*;

  logic  valid;
  logic  ready;
  word_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic  singular;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  output ready);
endinterface

[rtl/matrix3_invert.sv]
// Throughput: one matrix per cycle while no result is held; each
//   cofactor has its own 33-step restoring divider, one quotient bit
//   per pipeline stage.
// A held result stalls the whole pipeline in place; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits and sets the threshold to 1.
module matrix3_invert (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [m3inv_pkg::THR_W-1:0]  cfg_wdata,
  m3inv_mat_if.sink                    mat_in,
  m3inv_res_if.source                  mat_out
);
  import m3inv_pkg::*;

  localparam int unsigned NSTG = 6 + DIV_N + 1;

  logic              en;
  logic [NSTG-1:0]   vld;
  logic [THR_W-1:0]  thr;
  word_t             a [N_EL];

  // stage 1: products
  logic signed [PROD_W-1:0] pp1 [N_EL];
  logic signed [PROD_W-1:0] pn1 [N_EL];
  word_t                    row1 [3];
  // stage 2: cofactors
  logic signed [PROD_W-1:0] cf2 [N_EL];
  word_t                    row2 [3];
  // stage 3: det partial products
  logic [PROD_W-1:0]        lo3 [3];
  logic [CM_W-1:0]          hi3 [3];
  logic                     sn3 [3];
  logic signed [PROD_W-1:0] cf3 [N_EL];
  // stage 4: signed det terms
  logic [DT_W-1:0]          tm4 [3];
  logic signed [PROD_W-1:0] cf4 [N_EL];
  // stage 5: determinant
  logic [DT_W-1:0]          det5;
  logic signed [PROD_W-1:0] cf5 [N_EL];
  // stage 6: magnitudes, singular test
  logic [DM_W-1:0]          dm6;
  logic                     sg6;
  logic [CM_W-1:0]          cm6 [N_EL];
  logic                     ng6 [N_EL];
  // divider stages
  logic [DM_W-1:0]          dm  [DIV_N];
  logic                     sg  [DIV_N];
  logic [DM_W-1:0]          rem [DIV_N][N_EL];
  logic [QW-1:0]            qv  [DIV_N][N_EL];
  logic                     ov  [DIV_N][N_EL];
  logic                     ng  [DIV_N][N_EL];
  logic                     lsb [N_EL];
  logic [DM_W:0]            sh  [DIV_N-1][N_EL];
  logic [DM_W:0]            df  [DIV_N-1][N_EL];
  logic                     ge  [DIV_N-1][N_EL];
  // output register
  word_t                    r   [N_EL];
  logic                     sgo;

  // pipeline advances unless a result is held
  assign en           = !vld[NSTG-1] || mat_out.ready;
  assign mat_in.ready = en;

  assign a[0] = mat_in.m00;  assign a[1] = mat_in.m01;  assign a[2] = mat_in.m02;
  assign a[3] = mat_in.m10;  assign a[4] = mat_in.m11;  assign a[5] = mat_in.m12;
  assign a[6] = mat_in.m20;  assign a[7] = mat_in.m21;  assign a[8] = mat_in.m22;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], mat_in.valid};
    end
  end

  // divider step: shift in next numerator bit, compare, subtract
  always_comb begin
    for (int s = 1; s < DIV_N; s++) begin
      for (int k = 0; k < N_EL; k++) begin
        sh[s-1][k] = {rem[s-1][k], (s == 1) ? lsb[k] : 1'b0};
        ge[s-1][k] = sh[s-1][k] >= {1'b0, dm[s-1]};
        df[s-1][k] = sh[s-1][k] - {1'b0, dm[s-1]};
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int k = 0; k < N_EL; k++) begin
        pp1[k] <= PROD_W'(a[CF_PA[k]]) * PROD_W'(a[CF_PB[k]]);
        pn1[k] <= PROD_W'(a[CF_NA[k]]) * PROD_W'(a[CF_NB[k]]);
      end
      for (int j = 0; j < 3; j++) row1[j] <= a[j];
      // stage 2
      for (int k = 0; k < N_EL; k++) cf2[k] <= pp1[k] - pn1[k];
      row2 <= row1;
      // stage 3: |c| * |m| as two partial products, of the low 32 and high 31 bits of |c|
      for (int j = 0; j < 3; j++) begin
        logic [PROD_W-1:0] cm;
        logic [WORD_W-1:0] mm;
        cm = cf2[3*j][PROD_W-1] ? (~cf2[3*j] + 1'b1) : cf2[3*j];
        mm = row2[j][WORD_W-1] ? (~row2[j] + 1'b1) : row2[j];
        lo3[j] <= PROD_W'(cm[31:0]) * PROD_W'(mm);
        hi3[j] <= CM_W'(cm[CM_W-1:32]) * CM_W'(mm);
        sn3[j] <= cf2[3*j][PROD_W-1] ^ row2[j][WORD_W-1];
      end
      cf3 <= cf2;
      // stage 4
      for (int j = 0; j < 3; j++) begin
        logic [DT_W-1:0] t;
        t = DT_W'({hi3[j], 32'b0}) + DT_W'(lo3[j]);
        tm4[j] <= sn3[j] ? (~t + 1'b1) : t;
      end
      cf4 <= cf3;
      // stage 5
      det5 <= tm4[0] + tm4[1] + tm4[2];
      cf5  <= cf4;
      // stage 6
      begin
        logic [DT_W-1:0] dabs;
        dabs = det5[DT_W-1] ? (~det5 + 1'b1) : det5;
        dm6  <= dabs[DM_W-1:0];
        sg6  <= (dabs[DM_W-1:0] < DM_W'({thr, 32'b0})) || (dabs[DM_W-1:0] == '0);
        for (int k = 0; k < N_EL; k++) begin
          logic [PROD_W-1:0] c;
          c = cf5[k][PROD_W-1] ? (~cf5[k] + 1'b1) : cf5[k];
          cm6[k] <= c[CM_W-1:0];
          ng6[k] <= cf5[k][PROD_W-1] ^ det5[DT_W-1];
        end
      end
      // divider stage 0: overflow check of the top quotient bits
      dm[0] <= dm6;
      sg[0] <= sg6;
      for (int k = 0; k < N_EL; k++) begin
        rem[0][k] <= DM_W'(cm6[k][CM_W-1:1]);
        ov[0][k]  <= DM_W'(cm6[k][CM_W-1:1]) >= dm6;
        qv[0][k]  <= '0;
        ng[0][k]  <= ng6[k];
        lsb[k]    <= cm6[k][0];
      end
      // divider steps
      for (int s = 1; s < DIV_N; s++) begin
        dm[s] <= dm[s-1];
        sg[s] <= sg[s-1];
        for (int k = 0; k < N_EL; k++) begin
          rem[s][k] <= ge[s-1][k] ? df[s-1][k][DM_W-1:0] : sh[s-1][k][DM_W-1:0];
          qv[s][k]  <= {qv[s-1][k][QW-2:0], ge[s-1][k]};
          ov[s][k]  <= ov[s-1][k];
          ng[s][k]  <= ng[s-1][k];
        end
      end
      // output: sign, saturation, singular override
      sgo <= sg[DIV_N-1];
      for (int k = 0; k < N_EL; k++) begin
        logic [QW-1:0] q;
        q = qv[DIV_N-1][k];
        if (sg[DIV_N-1]) begin
          r[k] <= '0;
        end else if (ng[DIV_N-1][k]) begin
          if (ov[DIV_N-1][k] || q > QW'(SAT_NEG)) r[k] <= SAT_NEG;
          else                                    r[k] <= ~q[WORD_W-1:0] + 1'b1;
        end else begin
          if (ov[DIV_N-1][k] || q[QW-1:WORD_W-1] != '0) r[k] <= SAT_POS;
          else                                          r[k] <= q[WORD_W-1:0];
        end
      end
    end
  end

  assign mat_out.valid    = vld[NSTG-1];
  assign mat_out.singular = sgo;
  assign mat_out.r00 = r[0];  assign mat_out.r01 = r[1];  assign mat_out.r02 = r[2];
  assign mat_out.r10 = r[3];  assign mat_out.r11 = r[4];  assign mat_out.r12 = r[5];
  assign mat_out.r20 = r[6];  assign mat_out.r21 = r[7];  assign mat_out.r22 = r[8];

  // checks
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    mat_out.valid && mat_out.singular |-> mat_out.r00 == 0 && mat_out.r11 == 0
      && mat_out.r22 == 0 && mat_out.r01 == 0 && mat_out.r20 == 0)
    else $error("singular result with nonzero elements");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    mat_out.valid && !mat_out.ready |-> !mat_in.ready)
    else $error("input taken while pipeline is stalled");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    mat_in.valid && mat_in.ready |=> vld[0])
    else $error("accepted word lost at pipeline entry");

  a_nonzero_div: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !sg6 |-> dm6 != '0)
    else $error("divider fed with zero determinant");

endmodule
